// ----- design/rhc_pkg.sv -----
`timescale 1ns / 1ps
package rhc_pkg;

    localparam int FRAC_BITS = 16;

    // long division of an 18-bit dividend by a 9-bit divisor, one quotient bit per stage
    localparam int DIV_NW = 18;
    localparam int DIV_DW = 9;
    localparam int DIV_QW = 9;
    localparam int DIV_ST = DIV_QW;

    localparam int QDEPTH = 4;

    localparam logic [8:0]  HUE_WRAP  = 9'd360;
    // floor(w / 60) == (w * RECIP60) >> RECIP_SH for every w below 2**14
    localparam logic [15:0] RECIP60   = 16'd34953;
    localparam int          RECIP_SH  = 21;

    typedef enum logic {
        CMD_RGB2HSL = 1'b0,
        CMD_HSL2RGB = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                   cmd;
        // rgb to hsl
        logic [DIV_NW-1:0]      hnum;
        logic [DIV_DW-1:0]      hden;
        logic [DIV_NW-1:0]      snum;
        logic [DIV_DW-1:0]      sden;
        logic                   gray;
        logic [7:0]             light;
        // hsl to rgb
        logic [FRAC_BITS-1:0]   dl;
        logic [FRAC_BITS-1:0]   ds;
        logic [FRAC_BITS-1:0]   prodh;
        logic                   low;
        logic [6:0]             f_r;
        logic [6:0]             f_g;
        logic [6:0]             f_b;
    } t_job;

    // weight of (q - p) in sixtieths for a channel angle
    function automatic logic [6:0] ang_weight(input logic [8:0] a);
        logic [8:0] t;
        t = 9'd240 - a;
        if (a < 9'd60) begin
            ang_weight = a[6:0];
        end else if (a < 9'd180) begin
            ang_weight = 7'd60;
        end else if (a < 9'd240) begin
            ang_weight = t[6:0];
        end else begin
            ang_weight = 7'd0;
        end
    endfunction

    function automatic logic [8:0] wrap360(input logic [9:0] a);
        logic [9:0] t;
        t = a - {1'b0, HUE_WRAP};
        if (a >= {1'b0, HUE_WRAP}) begin
            wrap360 = t[8:0];
        end else begin
            wrap360 = a[8:0];
        end
    endfunction

endpackage

// ----- design/rhc_front.sv -----
`timescale 1ns / 1ps
module rhc_front import rhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [8:0]  i_hue_in,
    input  logic [7:0]  i_sat_in,
    input  logic [7:0]  i_light_in,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    logic       r_fv, n_fv;
    t_job       r_job, n_job;

    logic [7:0]  mx, mn, d;
    logic [8:0]  sum;
    logic [11:0] num;
    logic [17:0] num60;
    logic [8:0]  h;
    logic [2*FRAC_BITS-1:0] prod;

    always_comb begin
        mx = i_red_in;
        mn = i_red_in;
        if (i_green_in > mx) mx = i_green_in;
        if (i_blue_in > mx)  mx = i_blue_in;
        if (i_green_in < mn) mn = i_green_in;
        if (i_blue_in < mn)  mn = i_blue_in;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        // sector offset keeps the numerator non-negative
        if (mx == i_red_in) begin
            num = 12'(6 * d) + {4'b0, i_green_in} - {4'b0, i_blue_in};
        end else if (mx == i_green_in) begin
            num = 12'(2 * d) + {4'b0, i_blue_in} - {4'b0, i_red_in};
        end else begin
            num = 12'(4 * d) + {4'b0, i_red_in} - {4'b0, i_green_in};
        end
        num60 = {6'b0, num} * 18'd60;

        h    = wrap360({1'b0, i_hue_in});
        prod = {i_light_in, {(FRAC_BITS-8){1'b0}}} * {i_sat_in, {(FRAC_BITS-8){1'b0}}};

        n_job.cmd   = t_cmd'(i_cmd);
        n_job.hnum  = num60;
        n_job.hden  = {1'b0, d};
        n_job.snum  = {2'b0, d, 8'b0};
        n_job.sden  = (sum <= 9'd255) ? sum : (9'd510 - sum);
        n_job.gray  = (d == 8'd0);
        n_job.light = sum[8:1];
        n_job.dl    = {i_light_in, {(FRAC_BITS-8){1'b0}}};
        n_job.ds    = {i_sat_in, {(FRAC_BITS-8){1'b0}}};
        n_job.prodh = prod[2*FRAC_BITS-1:FRAC_BITS];
        n_job.low   = ~i_light_in[7];
        n_job.f_r   = ang_weight(wrap360({1'b0, h} + 10'd120));
        n_job.f_g   = ang_weight(h);
        n_job.f_b   = ang_weight(wrap360({1'b0, h} + 10'd240));
    end

    assign o_ready     = !r_fv || i_job_ready;
    assign o_job_valid = r_fv;
    assign o_job       = r_job;

    always_comb begin
        n_fv = r_fv;
        if (o_ready) begin
            n_fv = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- design/rhc_queue.sv -----
`timescale 1ns / 1ps
module rhc_queue import rhc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_job           r_mem [QDEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           push, pop;

    assign o_push_ready = (r_cnt != CW'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + CW'(push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QDEPTH))
        else $error("queue count out of range");

    ptr_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_wp - r_rp) == r_cnt[PW-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- design/rhc_div.sv -----
`timescale 1ns / 1ps
module rhc_div import rhc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quot
);

    localparam int LW = DIV_NW - DIV_DW;

    logic [DIV_DW-1:0] r_rem [DIV_ST];
    logic [LW-1:0]     r_nb  [DIV_ST];
    logic [DIV_DW-1:0] r_den [DIV_ST];
    logic [DIV_QW-1:0] r_q   [DIV_ST];

    logic [DIV_DW-1:0] n_rem [DIV_ST];
    logic [LW-1:0]     n_nb  [DIV_ST];
    logic [DIV_DW-1:0] n_den [DIV_ST];
    logic [DIV_QW-1:0] n_q   [DIV_ST];

    // dividend top bits are below the divisor, so the quotient fits DIV_QW bits
    always_comb begin
        for (int s = 0; s < DIV_ST; s++) begin
            logic [DIV_DW-1:0] rem_in;
            logic [LW-1:0]     nb_in;
            logic [DIV_DW-1:0] den_in;
            logic [DIV_QW-1:0] q_in;
            logic [DIV_DW:0]   t;
            logic [DIV_DW:0]   t_sub;
            if (s == 0) begin
                rem_in = i_num[DIV_NW-1:LW];
                nb_in  = i_num[LW-1:0];
                den_in = i_den;
                q_in   = '0;
            end else begin
                rem_in = r_rem[s-1];
                nb_in  = r_nb[s-1];
                den_in = r_den[s-1];
                q_in   = r_q[s-1];
            end
            t     = {rem_in, nb_in[LW-1]};
            t_sub = t - {1'b0, den_in};
            if (t >= {1'b0, den_in}) begin
                n_rem[s] = t_sub[DIV_DW-1:0];
            end else begin
                n_rem[s] = t[DIV_DW-1:0];
            end
            n_nb[s]  = {nb_in[LW-2:0], 1'b0};
            n_den[s] = den_in;
            n_q[s]   = {q_in[DIV_QW-2:0], (t >= {1'b0, den_in})};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_ST; s++) begin
                r_rem[s] <= n_rem[s];
                r_nb[s]  <= n_nb[s];
                r_den[s] <= n_den[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_quot = r_q[DIV_ST-1];

endmodule

// ----- design/rhc_back.sv -----
`timescale 1ns / 1ps
module rhc_back import rhc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [8:0] o_hue_out,
    output logic [7:0] o_sat_out,
    output logic [7:0] o_light_out,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out
);

    localparam int F      = FRAC_BITS;
    localparam int ZW     = F + 6;
    localparam int RGB_ST = 4;

    logic en;

    logic       r_vld   [DIV_ST];
    t_cmd       r_cmd   [DIV_ST];
    logic       r_gray  [DIV_ST];
    logic [7:0] r_light [DIV_ST];
    logic [23:0] r_rgb  [RGB_ST:DIV_ST-1];

    logic [F:0]    r_q0, r_p0, n_q0, n_p0;
    logic [6:0]    r_f0 [3];
    logic [ZW-1:0] r_m1 [3];
    logic [ZW-1:0] r_p60;
    logic [13:0]   r_w2 [3];
    logic [29:0]   r_y3 [3];

    logic       r_ov;
    logic [8:0] r_hue;
    logic [7:0] r_sat, r_lo, r_red, r_green, r_blue;

    logic [DIV_QW-1:0] qh, qs;
    logic [F:0]        dqp;
    logic [F+7:0]      mprod [3];
    logic [F+6:0]      p60w;
    logic [ZW-1:0]     z [3];
    logic [7:0]        chan [3];
    logic [F:0]        two_dl;

    assign en          = !r_ov || i_ready;
    assign o_job_ready = en;

    rhc_div u_div_hue (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_job.hnum),
        .i_den  (i_job.hden),
        .o_quot (qh)
    );

    rhc_div u_div_sat (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_job.snum),
        .i_den  (i_job.sden),
        .o_quot (qs)
    );

    // q and p of the hue-to-channel rule
    always_comb begin
        two_dl = {i_job.dl, 1'b0};
        if (i_job.low) begin
            n_q0 = {1'b0, i_job.dl} + {1'b0, i_job.prodh};
        end else begin
            n_q0 = {1'b0, i_job.dl} + {1'b0, i_job.ds} - {1'b0, i_job.prodh};
        end
        n_p0 = (two_dl > n_q0) ? two_dl - n_q0 : '0;
    end

    // channel = floor(floor((60p + (q-p)*f) >> (F-8)) / 60)
    always_comb begin
        dqp  = r_q0 - r_p0;
        p60w = r_p0 * 6'd60;
        for (int c = 0; c < 3; c++) begin
            mprod[c] = dqp * r_f0[c];
            z[c]     = r_p60 + r_m1[c];
            chan[c]  = (r_y3[c][29:RECIP_SH] > 9'd255) ? 8'd255 : r_y3[c][RECIP_SH+7:RECIP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_ST; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_job_valid;
            for (int s = 1; s < DIV_ST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_ov <= r_vld[DIV_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[0]   <= i_job.cmd;
            r_gray[0]  <= i_job.gray;
            r_light[0] <= i_job.light;
            for (int s = 1; s < DIV_ST; s++) begin
                r_cmd[s]   <= r_cmd[s-1];
                r_gray[s]  <= r_gray[s-1];
                r_light[s] <= r_light[s-1];
            end
            r_q0  <= n_q0;
            r_p0  <= n_p0;
            r_f0[0] <= i_job.f_r;
            r_f0[1] <= i_job.f_g;
            r_f0[2] <= i_job.f_b;
            r_p60 <= p60w[ZW-1:0];
            for (int c = 0; c < 3; c++) begin
                r_m1[c] <= mprod[c][ZW-1:0];
                r_w2[c] <= z[c][ZW-1:F-8];
                r_y3[c] <= r_w2[c] * RECIP60;
            end
            r_rgb[RGB_ST] <= {chan[0], chan[1], chan[2]};
            for (int s = RGB_ST + 1; s < DIV_ST; s++) begin
                r_rgb[s] <= r_rgb[s-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_cmd[DIV_ST-1] == CMD_RGB2HSL) begin
                r_hue   <= r_gray[DIV_ST-1] ? 9'd0 : wrap360({1'b0, qh});
                r_sat   <= (r_gray[DIV_ST-1]) ? 8'd0 : ((qs > 9'd255) ? 8'd255 : qs[7:0]);
                r_lo    <= r_light[DIV_ST-1];
                r_red   <= 8'd0;
                r_green <= 8'd0;
                r_blue  <= 8'd0;
            end else begin
                r_hue   <= 9'd0;
                r_sat   <= 8'd0;
                r_lo    <= 8'd0;
                r_red   <= r_rgb[DIV_ST-1][23:16];
                r_green <= r_rgb[DIV_ST-1][15:8];
                r_blue  <= r_rgb[DIV_ST-1][7:0];
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_hue_out   = r_hue;
    assign o_sat_out   = r_sat;
    assign o_light_out = r_lo;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

// ----- design/rgb_hsl_converter.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_cmd, i_red_in .. i_blue_in, i_hue_in,
//                                           i_sat_in, i_light_in
// output    out        o_valid / i_ready    o_hue_out, o_sat_out, o_light_out,
//                                           o_red_out, o_green_out, o_blue_out
//
// one transaction per clock sustained while i_ready is high; each job passes through
// the front register, queue, 9-stage long division pipeline and output register
// the queue holds 4 jobs so the front keeps taking input while the back stalls
// the back pipeline stalls as a whole when a result waits on i_ready
// reset (synchronous, active low) empties the front, queue and pipeline
module rgb_hsl_converter import rhc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    input  logic [8:0] i_hue_in,
    input  logic [7:0] i_sat_in,
    input  logic [7:0] i_light_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [8:0] o_hue_out,
    output logic [7:0] o_sat_out,
    output logic [7:0] o_light_out,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out
);

    logic f_valid, f_ready, b_valid, b_ready;
    t_job f_job, b_job;

    rhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_hue_in    (i_hue_in),
        .i_sat_in    (i_sat_in),
        .i_light_in  (i_light_in),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    rhc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_job   (f_job),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_job    (b_job)
    );

    rhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (b_valid),
        .o_job_ready (b_ready),
        .i_job       (b_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hue_out   (o_hue_out),
        .o_sat_out   (o_sat_out),
        .o_light_out (o_light_out),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    hue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue_out < HUE_WRAP)
        else $error("hue out of range");

    one_side_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_hue_out == 9'd0 && o_sat_out == 8'd0 && o_light_out == 8'd0) ||
                     (o_red_out == 8'd0 && o_green_out == 8'd0 && o_blue_out == 8'd0)))
        else $error("both result groups nonzero");

    gray_has_no_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sat_out == 8'd0 && o_red_out == 8'd0 && o_green_out == 8'd0 &&
         o_blue_out == 8'd0 && o_light_out != 8'd0) |-> o_hue_out == 9'd0)
        else $error("zero saturation with nonzero hue");

    no_result_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule
